### src/esk_pkg.sv
// ============================================================================
// Escape sequence key matcher package
// Shared constants, types and helper functions for the arrow-key matcher.
// ============================================================================
`default_nettype none

package esk_pkg;

  // Key table dimensions
  localparam int NUM_KEYS     = 4;
  localparam int NUM_CFG_REGS = 4;
  localparam int KEY_CHARS    = 8;
  localparam int SLOT_CHARS   = 8;
  localparam int KEY_LIMIT    = (KEY_CHARS < SLOT_CHARS) ? KEY_CHARS : SLOT_CHARS;

  // Field widths
  localparam int CHAR_W    = 7;
  localparam int SEQ_W     = CHAR_W * SLOT_CHARS;
  localparam int PROG_W    = 3;
  localparam int LEN_W     = 4;
  localparam int KEY_IDX_W = $clog2(NUM_KEYS);
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 8;

  typedef logic [SEQ_W-1:0]     key_seq_t;
  typedef logic [PROG_W-1:0]    prog_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CHAR_W-1:0]    char_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  // Request kinds carried on tuser
  localparam logic REQ_CHAR    = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  // Control codes for the four arrow keys
  localparam char_t CODE_LEFT  = 7'd2;
  localparam char_t CODE_RIGHT = 7'd6;
  localparam char_t CODE_UP    = 7'd16;
  localparam char_t CODE_DOWN  = 7'd14;
  localparam char_t CHAR_NONE  = 7'd0;

  // One output run: a flushed key prefix, optionally followed by a tail character.
  typedef struct packed {
    key_seq_t seq;
    prog_t    pfx_len;
    logic     has_tail;
    char_t    tail;
  } run_desc_t;

  // Control code delivered when a key string completes.
  function automatic char_t key_code(key_idx_t k);
    char_t code;
    unique case (k)
      key_idx_t'(0): code = CODE_LEFT;
      key_idx_t'(1): code = CODE_RIGHT;
      key_idx_t'(2): code = CODE_UP;
      key_idx_t'(3): code = CODE_DOWN;
      default:       code = CHAR_NONE;
    endcase
    return code;
  endfunction

  // Character i of a packed key string.
  function automatic char_t seq_char(key_seq_t s, prog_t i);
    return s[CHAR_W*i +: CHAR_W];
  endfunction

endpackage

`default_nettype wire

### src/esk_matcher.sv
// ============================================================================
// Key string matcher
// Holds the key strings and per-key progress, decides each request in one
// pass and registers the resulting output run.
// ============================================================================
`default_nettype none

module esk_matcher
  import esk_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SEQ_W-1:0]     cfg_data,
  // Request side
  input  wire logic                 req_valid,
  output logic                      req_ready,
  input  wire logic                 req_type,
  input  wire logic [IN_DATA_W-1:0] in_char,
  // Run descriptor towards the serialiser
  output logic                      desc_valid,
  output run_desc_t                 desc,
  input  wire logic                 desc_take
);

  key_seq_t  key_seq  [NUM_KEYS];
  prog_t     progress [NUM_KEYS];
  prog_t     progress_next [NUM_KEYS];
  len_t      key_len  [NUM_KEYS];
  logic      adv      [NUM_KEYS];
  logic      done     [NUM_KEYS];

  logic      req_fire;
  char_t     c;
  logic      hit;
  logic      done_any;
  key_idx_t  done_key;
  prog_t     best_p;
  key_idx_t  best_key;
  logic      pending;
  logic      make_run;
  run_desc_t desc_next;

  assign c         = in_char[CHAR_W-1:0];
  assign req_ready = !desc_valid || desc_take;
  assign req_fire  = req_valid && req_ready;

  // Per-key string length and advance test against the incoming character.
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_len[k] = len_t'(KEY_LIMIT);
      for (int i = KEY_LIMIT - 1; i >= 0; i--) begin
        if (seq_char(key_seq[k], prog_t'(i)) == CHAR_NONE) begin
          key_len[k] = len_t'(i);
        end
      end
      adv[k]  = (key_len[k] != '0) && ({1'b0, progress[k]} < key_len[k]) &&
                (seq_char(key_seq[k], progress[k]) == c);
      done[k] = adv[k] && (({1'b0, progress[k]} + len_t'(1)) == key_len[k]);
      progress_next[k] = adv[k] ? progress[k] + prog_t'(1) : '0;
    end
  end

  // First completing key, any advance, and the longest pending prefix.
  always_comb begin
    hit      = 1'b0;
    done_any = 1'b0;
    done_key = '0;
    best_p   = '0;
    best_key = '0;
    pending  = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      hit     = hit || adv[k];
      pending = pending || (progress[k] != '0);
      if (done[k] && !done_any) begin
        done_any = 1'b1;
        done_key = key_idx_t'(k);
      end
      if (progress[k] > best_p) begin
        best_p   = progress[k];
        best_key = key_idx_t'(k);
      end
    end
  end

  // Build the output run for this request.
  always_comb begin
    make_run           = 1'b1;
    desc_next.seq      = key_seq[best_key];
    desc_next.pfx_len  = best_p;
    desc_next.has_tail = 1'b1;
    desc_next.tail     = c;
    if (req_type == REQ_TIMEOUT) begin
      make_run           = (best_p != '0);
      desc_next.has_tail = 1'b0;
      desc_next.tail     = CHAR_NONE;
    end else if (done_any) begin
      desc_next.pfx_len  = '0;
      desc_next.tail     = key_code(done_key);
    end else if (hit) begin
      make_run = 1'b0;
    end
  end

  // Key strings, progress and the run descriptor register.
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_seq[k]  <= '0;
        progress[k] <= '0;
      end
    end else begin
      if (req_fire) begin
        desc_valid <= make_run;
        desc       <= desc_next;
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (req_type == REQ_CHAR && !done_any && hit) begin
            progress[k] <= progress_next[k];
          end else begin
            progress[k] <= '0;
          end
        end
      end else if (desc_take) begin
        desc_valid <= 1'b0;
      end
      // A key write replaces the string and drops its progress.
      if (cfg_we) begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (k < NUM_CFG_REGS && cfg_index == CFG_IDX_W'(k)) begin
            key_seq[k]  <= cfg_data;
            progress[k] <= '0;
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A timeout always leaves no partial match behind.
  a_timeout_clears: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req_type == REQ_TIMEOUT && !cfg_we) |=> !pending)
    else $error("progress left after timeout");

  // A waiting run is held until the serialiser takes it.
  a_desc_hold: assert property (@(posedge clk) disable iff (rst)
    (desc_valid && !desc_take) |=> (desc_valid && $stable(desc)))
    else $error("run descriptor changed while waiting");

  // Every registered run carries at least one character.
  a_desc_nonempty: assert property (@(posedge clk) disable iff (rst)
    desc_valid |-> (desc.has_tail || desc.pfx_len != '0))
    else $error("empty run registered");
`endif

endmodule

`default_nettype wire

### src/esk_serializer.sv
// ============================================================================
// Run serialiser
// Emits a registered run one character per cycle while m_tready is high.
// ============================================================================
`default_nettype none

module esk_serializer
  import esk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Run descriptor from the matcher
  input  wire logic                  desc_valid,
  input  wire run_desc_t             desc,
  output logic                       desc_take,
  // Output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tlast
);

  run_desc_t run;
  logic      busy;
  prog_t     idx;
  logic      at_last;
  logic      m_fire;
  logic      load;
  char_t     cur_char;

  // Current character and end-of-run marker.
  assign at_last  = run.has_tail ? (idx == run.pfx_len)
                                 : (idx == run.pfx_len - prog_t'(1));
  assign cur_char = (idx < run.pfx_len) ? seq_char(run.seq, idx) : run.tail;

  assign m_tvalid = busy;
  assign m_tlast  = at_last;
  assign m_tdata  = {{(OUT_DATA_W-CHAR_W){1'b0}}, cur_char};

  assign m_fire    = busy && m_tready;
  assign load      = desc_valid && (!busy || (m_fire && at_last));
  assign desc_take = load;

  // Run register and character index.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      run  <= desc;
      idx  <= '0;
    end else if (m_fire) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + prog_t'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The output goes idle after the last character when nothing follows.
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (m_fire && at_last && !load) |=> !busy)
    else $error("serialiser stayed busy after end of run");

  // The index never passes the end of the run.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= run.pfx_len))
    else $error("run index out of range");
`endif

endmodule

`default_nettype wire

### src/escape_sequence_key_matcher.sv
// Request path: an accepted request is registered as a run descriptor in the matcher,
// then loaded into the serialiser run register, which drives the result stream.
// Throughput: one request per cycle while the run descriptor is empty or being taken;
// a run of n results goes out through the single-character output serialiser.
// Requests with no result (partial match, idle timeout) never reach the output.
// Reset (synchronous, rst high) clears all key strings, all progress and both stages.
// ============================================================================
// Escape sequence key matcher
// Maps configured arrow-key escape strings on a character stream to control codes.
// ============================================================================
`default_nettype none

module escape_sequence_key_matcher
  import esk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration: 0 left, 1 right, 2 up, 3 down key string
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [SEQ_W-1:0]      cfg_data,
  // Request stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] in_char
  input  wire logic                  s_tuser,   // [0] req_type
  // Result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [6:0] out_char, [7] zero
  output logic                       m_tlast    // last_of_run
);

  logic      desc_valid;
  run_desc_t desc;
  logic      desc_take;

  esk_matcher u_matcher (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_type   (s_tuser),
    .in_char    (s_tdata),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take)
  );

  esk_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .desc_take  (desc_take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

`default_nettype wire
